// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property p must hold at every clock edge outside reset.
`define AST_HOLD(lbl, clk, rstn, p, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (p)) else $error(msg);

// When a holds, c must hold in the next cycle.
`define AST_NEXT(lbl, clk, rstn, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) else $error(msg);

`endif

// ----- hdl/orm_pkg.sv -----
`default_nettype none
package orm_pkg;
	localparam int ID_W          = 10;
	localparam int ID_COUNT      = 1 << ID_W;
	localparam int CAP_W         = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam int LOAD_W        = 11;
	localparam int DATA_W        = 16;
	localparam int MAX_REQ_DEF   = 1024;
	localparam int MAX_SLOTS_DEF = 16;

	typedef struct packed {
		logic clr;
		logic ld;
		logic br;
		logic bl;
		logic bw;
		logic fr;
		logic fc;
		logic scan;
		logic evict;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic idx_one;
		logic idx_last;
		logic hit;
		logic fill_ok;
		logic scan_done;
		logic out_free;
	} sts_t;
endpackage
`default_nettype wire

// ----- hdl/orm_ctrl.sv -----
`default_nettype none
module orm_ctrl (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           s_tvalid,
	input  wire           s_tlast,
	output logic          s_tready,
	input  orm_pkg::sts_t sts,
	output orm_pkg::cmd_t cmd
);
	import orm_pkg::*;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_LOAD  = 4'd1;
	localparam logic [3:0] ST_BR    = 4'd2;
	localparam logic [3:0] ST_BL    = 4'd3;
	localparam logic [3:0] ST_BW    = 4'd4;
	localparam logic [3:0] ST_FR    = 4'd5;
	localparam logic [3:0] ST_FC    = 4'd6;
	localparam logic [3:0] ST_SCAN  = 4'd7;
	localparam logic [3:0] ST_EVICT = 4'd8;
	localparam logic [3:0] ST_DONE  = 4'd9;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				s_tready = 1'b1;
				cmd.ld   = s_tvalid;
				if (s_tvalid && s_tlast) state_d = ST_BR;
			end
			ST_BR: begin
				cmd.br  = 1'b1;
				state_d = ST_BL;
			end
			ST_BL: begin
				cmd.bl  = 1'b1;
				state_d = ST_BW;
			end
			ST_BW: begin
				cmd.bw  = 1'b1;
				state_d = sts.idx_one ? ST_FR : ST_BR;
			end
			ST_FR: begin
				cmd.fr  = 1'b1;
				state_d = ST_FC;
			end
			ST_FC: begin
				cmd.fc = 1'b1;
				if (sts.hit || sts.fill_ok) begin
					state_d = sts.idx_last ? ST_DONE : ST_FR;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) state_d = ST_EVICT;
			end
			ST_EVICT: begin
				cmd.evict = 1'b1;
				state_d   = sts.idx_last ? ST_DONE : ST_FR;
			end
			ST_DONE: begin
				cmd.finish = sts.out_free;
				if (sts.out_free) state_d = ST_LOAD;
			end
			default: state_d = ST_CLEAR;
		endcase
	end
endmodule
`default_nettype wire

// ----- hdl/orm_dp.sv -----
`default_nettype none
module orm_dp #(
	parameter int MAX_REQUESTS = orm_pkg::MAX_REQ_DEF,
	parameter int MAX_SLOTS    = orm_pkg::MAX_SLOTS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire  [orm_pkg::CAP_W-1:0]   cfg_wdata,
	input  wire  [orm_pkg::ID_W-1:0]    in_id,
	input  wire                         in_last,
	input  orm_pkg::cmd_t               cmd,
	output orm_pkg::sts_t               sts,
	input  wire                         out_ready,
	output logic                        out_valid,
	output logic [orm_pkg::LOAD_W-1:0]  out_count,
	output logic                        out_ovf
);
	import orm_pkg::*;

	localparam int CW  = $clog2(MAX_REQUESTS + 1);
	localparam int AW  = $clog2(MAX_REQUESTS);
	localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int SCW = $clog2(MAX_SLOTS + 1);
	localparam logic [CW-1:0] NEVER = CW'(MAX_REQUESTS);

	logic [ID_W-1:0]  req_mem [MAX_REQUESTS];
	logic [CW-1:0]    nu_mem  [MAX_REQUESTS];
	logic [CW-1:0]    ls_mem  [ID_COUNT];

	logic [CAP_W-1:0] cap_q;
	logic [CW-1:0]    cnt_q, idx_q, loads_q;
	logic             drop_q;
	logic [ID_W-1:0]  clr_q;
	logic [ID_W-1:0]  req_rd_q;
	logic [CW-1:0]    nu_rd_q, ls_rd_q;

	logic [ID_W-1:0]  slot_item_q [MAX_SLOTS];
	logic [CW-1:0]    slot_nu_q   [MAX_SLOTS];
	logic [MAX_SLOTS-1:0] valid_q;
	logic [SW-1:0]    scan_t_q, best_i_q;
	logic             best_v_q;
	logic [CW-1:0]    best_nu_q;

	logic             cnt_full, hit_f, free_f;
	logic [SW-1:0]    hit_i, free_i, vic_i;
	logic [SCW-1:0]   used, eff_cap;
	logic [AW-1:0]    rd_addr, bw_addr;
	logic             ls_we;
	logic [ID_W-1:0]  ls_waddr;
	logic [CW-1:0]    ls_wdata;

	assign cnt_full = (cnt_q == NEVER);
	assign rd_addr  = cmd.br ? AW'(idx_q - 1'b1) : AW'(idx_q);
	assign bw_addr  = AW'(idx_q - 1'b1);
	assign vic_i    = best_v_q ? best_i_q : '0;

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = SCW'(1);
		end else if (int'(cap_q) > MAX_SLOTS) begin
			eff_cap = SCW'(MAX_SLOTS);
		end else begin
			eff_cap = SCW'(cap_q);
		end
	end

	always_comb begin
		hit_f  = 1'b0;
		hit_i  = '0;
		free_f = 1'b0;
		free_i = '0;
		for (int s = 0; s < MAX_SLOTS; s++) begin
			if (valid_q[s]) begin
				if (slot_item_q[s] == req_rd_q && !hit_f) begin
					hit_f = 1'b1;
					hit_i = SW'(s);
				end
			end else if (!free_f) begin
				free_f = 1'b1;
				free_i = SW'(s);
			end
		end
		used = SCW'($countones(valid_q));
	end

	assign sts.clr_done  = (clr_q == '1);
	assign sts.idx_one   = (idx_q == CW'(1));
	assign sts.idx_last  = (idx_q == cnt_q - 1'b1);
	assign sts.hit       = hit_f;
	assign sts.fill_ok   = !hit_f && free_f && (used < eff_cap);
	assign sts.scan_done = (scan_t_q == SW'(MAX_SLOTS - 1));
	assign sts.out_free  = !out_valid || out_ready;

	always_comb begin
		ls_we    = 1'b0;
		ls_waddr = req_rd_q;
		ls_wdata = NEVER;
		if (cmd.clr) begin
			ls_we    = 1'b1;
			ls_waddr = clr_q;
		end else if (cmd.bw) begin
			ls_we    = 1'b1;
			ls_wdata = idx_q - 1'b1;
		end else if (cmd.fc) begin
			ls_we    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld && !cnt_full) req_mem[AW'(cnt_q)] <= in_id;
		if (cmd.bw) nu_mem[bw_addr] <= ls_rd_q;
		if (ls_we) ls_mem[ls_waddr] <= ls_wdata;
		if (cmd.br || cmd.fr) req_rd_q <= req_mem[rd_addr];
		if (cmd.fr) nu_rd_q <= nu_mem[rd_addr];
		if (cmd.bl) ls_rd_q <= ls_mem[req_rd_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.fc) begin
			if (hit_f) begin
				slot_nu_q[hit_i] <= nu_rd_q;
			end else if (sts.fill_ok) begin
				slot_item_q[free_i] <= req_rd_q;
				slot_nu_q[free_i]   <= nu_rd_q;
			end
		end
		if (cmd.evict) begin
			slot_item_q[vic_i] <= req_rd_q;
			slot_nu_q[vic_i]   <= nu_rd_q;
		end
		if (cmd.fc) begin
			best_i_q  <= '0;
			best_nu_q <= '0;
		end else if (cmd.scan && valid_q[scan_t_q] &&
				(!best_v_q || slot_nu_q[scan_t_q] > best_nu_q)) begin
			best_i_q  <= scan_t_q;
			best_nu_q <= slot_nu_q[scan_t_q];
		end
		if (cmd.finish) begin
			out_count <= LOAD_W'(loads_q);
			out_ovf   <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= CAP_RESET;
			cnt_q     <= '0;
			idx_q     <= '0;
			loads_q   <= '0;
			drop_q    <= 1'b0;
			clr_q     <= '0;
			valid_q   <= '0;
			scan_t_q  <= '0;
			best_v_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (cmd.clr) clr_q <= clr_q + 1'b1;
			if (cmd.ld) begin
				if (cnt_full) begin
					drop_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (in_last) idx_q <= cnt_full ? cnt_q : cnt_q + 1'b1;
			end
			if (cmd.bw) idx_q <= sts.idx_one ? '0 : idx_q - 1'b1;
			if (cmd.fc) begin
				scan_t_q <= '0;
				best_v_q <= 1'b0;
				if (hit_f || sts.fill_ok) idx_q <= idx_q + 1'b1;
				if (!hit_f) loads_q <= loads_q + 1'b1;
				if (sts.fill_ok) valid_q[free_i] <= 1'b1;
			end
			if (cmd.scan) begin
				scan_t_q <= scan_t_q + 1'b1;
				if (valid_q[scan_t_q]) best_v_q <= 1'b1;
			end
			if (cmd.evict) begin
				valid_q[vic_i] <= 1'b1;
				idx_q          <= idx_q + 1'b1;
			end
			if (cmd.finish) begin
				out_valid <= 1'b1;
				cnt_q     <= '0;
				loads_q   <= '0;
				drop_q    <= 1'b0;
				valid_q   <= '0;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ----- hdl/optimal_replacement_miss_counter_core.sv -----
// Belady optimal-replacement load counter.
// Slave stream: one request per transfer, tdata carries item_id, tlast marks
// the final request of a sequence. While loading, requests are taken one per
// cycle and buffered (up to MAX_REQUESTS; later ones dropped and flagged).
// After the tlast request, s_tready stays low while the sequence is replayed:
// a backward pass of BR, BL and BW per request builds next-use positions,
// then a forward pass of FR and FC per request on a hit or free fill, with
// SCAN (all slots, one per cycle) and EVICT added when a victim is needed.
// Master stream: one result per sequence, tdata = load_count, tuser =
// overflow. The result sits in an output register; s_tready returns as soon
// as it is registered, so the next sequence loads while the result waits.
// If a previous result is still stalled, the block holds until it is taken.
// Reset: capacity returns to 16 and a clearing pass over all ID_COUNT (1024)
// last-use table entries runs, with s_tready low. cfg_we writes capacity.
`default_nettype none
module optimal_replacement_miss_counter_core #(
	parameter int MAX_REQUESTS = orm_pkg::MAX_REQ_DEF,
	parameter int MAX_SLOTS    = orm_pkg::MAX_SLOTS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire  [orm_pkg::CAP_W-1:0]   cfg_wdata,   // capacity
	input  wire                         s_tvalid,
	output logic                        s_tready,
	input  wire  [orm_pkg::DATA_W-1:0]  s_tdata,     // [9:0] item_id
	input  wire                         s_tlast,     // last_request
	output logic                        m_tvalid,
	input  wire                         m_tready,
	output logic [orm_pkg::DATA_W-1:0]  m_tdata,     // [10:0] load_count
	output logic                        m_tuser      // overflow
);
	import orm_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [LOAD_W-1:0] count;

	orm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	orm_dp #(
		.MAX_REQUESTS (MAX_REQUESTS),
		.MAX_SLOTS    (MAX_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_id     (s_tdata[ID_W-1:0]),
		.in_last   (s_tlast),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_count (count),
		.out_ovf   (m_tuser)
	);

	assign m_tdata = DATA_W'(count);
endmodule
`default_nettype wire

// ----- hdl/orm_chk.sv -----
`default_nettype none
`include "assert_macros.svh"
module orm_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        s_tlast,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [15:0] m_tdata
);
	`AST_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result dropped")
	`AST_NEXT(a_busy_after_last, clk, arst_n, s_tvalid && s_tready && s_tlast, !s_tready, "request taken during replay")
	`AST_HOLD(a_result_ready, clk, arst_n, !$rose(m_tvalid) || s_tready, "not loading after result")
	`AST_HOLD(a_loads_nonzero, clk, arst_n, !m_tvalid || (m_tdata[10:0] != 11'd0), "zero loads")
endmodule

bind optimal_replacement_miss_counter_core orm_chk u_chk (.*);
`default_nettype wire

// ----- tb/sv/optimal_replacement_miss_counter_core_tb.sv -----
`timescale 1ns / 1ps
module optimal_replacement_miss_counter_core_tb;
	import orm_pkg::*;

	localparam int MAX_REQ     = MAX_REQ_DEF;
	localparam int SLOTS       = MAX_SLOTS_DEF;
	localparam int NEVER       = MAX_REQ;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN       = 64;

	typedef struct {
		logic [LOAD_W-1:0] load_count;
		logic              overflow;
	} load_result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CAP_W-1:0]    cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [DATA_W-1:0]   s_tdata;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [DATA_W-1:0]   m_tdata;
	logic                m_tuser;

	logic [CAP_W-1:0]    capacity_model;
	logic [ID_W-1:0]     pending_ids[$];
	logic                pending_dropped;
	load_result_t        expected_loads[$];
	int                  error_count;
	int                  cycle_count;
	bit                  steady;

	optimal_replacement_miss_counter_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [LOAD_W-1:0] optimal_loads(input logic [CAP_W-1:0] cap_raw);
		int          cap;
		int          n;
		int          next_use[];
		int          last_seen[ID_COUNT];
		logic [ID_W-1:0] slot_id[SLOTS];
		int          slot_next[SLOTS];
		bit          slot_busy[SLOTS];
		int          loads;
		int          hit;
		int          free_slot;
		int          used;
		int          victim;
		cap = (cap_raw == 0) ? 1 : (cap_raw > SLOTS) ? SLOTS : int'(cap_raw);
		n = pending_ids.size();
		next_use = new[n];
		loads = 0;
		foreach (last_seen[k]) last_seen[k] = NEVER;
		foreach (slot_busy[k]) slot_busy[k] = 1'b0;
		for (int i = n - 1; i >= 0; i--) begin
			next_use[i] = last_seen[pending_ids[i]];
			last_seen[pending_ids[i]] = i;
		end
		for (int i = 0; i < n; i++) begin
			hit = -1;
			free_slot = -1;
			used = 0;
			for (int s = 0; s < SLOTS; s++) begin
				if (slot_busy[s]) begin
					used++;
					if (slot_id[s] == pending_ids[i] && hit < 0)
						hit = s;
				end else if (free_slot < 0) begin
					free_slot = s;
				end
			end
			if (hit >= 0) begin
				slot_next[hit] = next_use[i];
				continue;
			end
			loads++;
			if (used < cap && free_slot >= 0) begin
				victim = free_slot;
			end else begin
				victim = -1;
				for (int s = 0; s < SLOTS; s++)
					if (slot_busy[s] && (victim < 0 || slot_next[s] > slot_next[victim]))
						victim = s;
				if (victim < 0)
					victim = 0;
			end
			slot_id[victim] = pending_ids[i];
			slot_next[victim] = next_use[i];
			slot_busy[victim] = 1'b1;
		end
		return loads[LOAD_W-1:0];
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// buffer the accepted request; the closing one yields a result
	task automatic record_request(input logic [ID_W-1:0] id, input logic last);
		load_result_t r;
		if (pending_ids.size() < MAX_REQ)
			pending_ids.push_back(id);
		else
			pending_dropped = 1'b1;
		if (last) begin
			r.load_count = optimal_loads(capacity_model);
			r.overflow = pending_dropped;
			expected_loads.push_back(r);
			pending_ids.delete();
			pending_dropped = 1'b0;
		end
	endtask

	task automatic send_request(input logic [ID_W-1:0] id, input logic last);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(DATA_W-ID_W){1'b0}}, id};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		record_request(id, last);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_loads.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		capacity_model = value;
	endtask

	task automatic send_sequence(input int len, input int base, input int span);
		for (int i = 0; i < len; i++)
			send_request(ID_W'(base + $urandom_range(0, span)), i == len - 1);
	endtask

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			int stall;
			stall = steady ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_loads.size() == 0) begin
				report("unexpected result", m_tdata, -1);
			end else begin
				if (m_tdata[LOAD_W-1:0] != expected_loads[0].load_count)
					report("load_count", m_tdata[LOAD_W-1:0], expected_loads[0].load_count);
				if (m_tdata[DATA_W-1:LOAD_W] != 0)
					report("tdata pad", m_tdata[DATA_W-1:LOAD_W], 0);
				if (m_tuser != expected_loads[0].overflow)
					report("overflow", m_tuser, expected_loads[0].overflow);
				void'(expected_loads.pop_front());
			end
		end
	end

	task automatic test_directed();
		// reset capacity, single request and extreme ids
		send_request('0, 1'b1);
		send_request('1, 1'b0);
		send_request('1, 1'b0);
		send_request('0, 1'b1);
		set_capacity(5'd1);
		send_request(10'd1, 1'b0);
		send_request(10'd2, 1'b0);
		send_request(10'd1, 1'b0);
		send_request(10'd2, 1'b1);
		// zero acts as one
		set_capacity(5'd0);
		send_request(10'd7, 1'b0);
		send_request(10'd7, 1'b0);
		send_request(10'd8, 1'b1);
		// above the slot count acts as the slot count
		set_capacity(5'd31);
		send_sequence(20, 0, 19);
		// eviction picks a never-reused item over a reused one
		set_capacity(5'd2);
		send_request(10'd5, 1'b0);
		send_request(10'd6, 1'b0);
		send_request(10'd7, 1'b0);
		send_request(10'd8, 1'b0);
		send_request(10'd5, 1'b1);
	endtask

	task automatic test_random();
		logic [CAP_W-1:0] caps[] = '{5'd16, 5'd3, 5'd1, 5'd17, 5'd0, 5'd8, 5'd31};
		int sent;
		int len;
		int span;
		foreach (caps[p]) begin
			set_capacity(p == caps.size() - 1 ? CAP_W'($urandom_range(0, 31)) : caps[p]);
			sent = 0;
			steady = (p == 2);
			while (sent < 110) begin
				len = $urandom_range(1, 30);
				span = ($urandom_range(0, 9) == 0) ? ID_COUNT - 1 : $urandom_range(0, 24);
				send_sequence(len, $urandom_range(0, ID_COUNT - 1 - span), span);
				sent += len;
			end
			steady = 1'b0;
		end
	endtask

	task automatic test_overflow();
		set_capacity(5'd4);
		send_sequence(MAX_REQ + 6, 0, 40);
		send_sequence(5, 1000, 23);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		capacity_model = CAP_RESET;
		pending_dropped = 1'b0;
		error_count = 0;
		cycle_count = 0;
		steady = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random();
		test_overflow();
		wait_idle();
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
